### hdl/lkc_pkg.sv
// Shared constants and types for the LRU key cache.
// Used by every module of the block; depends on nothing.
package lkc_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int KEY_BITS    = 32;
  localparam int IN_KEY_W    = 32;
  localparam int OUT_KEY_W   = 32;
  localparam int CAP_W       = 7;
  localparam int RANK_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LOOKUP = 3'b010,
    S_UPDATE = 3'b100
  } state_t;

  typedef struct packed {
    logic load;
    logic compare;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic              write_key;
    logic [RANK_W-1:0] limit;
  } lane_upd_t;

endpackage

### hdl/lkc_lane.sv
// One entry of the cache: stored key, recency rank and the two lane compares.
// Depends on lkc_pkg.
module lkc_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          lane_valid,
  input  logic                          target,
  input  logic [lkc_pkg::KEY_BITS-1:0]  key_in,
  input  logic [lkc_pkg::RANK_W-1:0]    last_rank,
  input  lkc_pkg::lane_upd_t            upd,
  output logic                          match,
  output logic                          oldest,
  output logic [lkc_pkg::KEY_BITS-1:0]  key_o,
  output logic [lkc_pkg::RANK_W-1:0]    rank_o
);

  logic [lkc_pkg::KEY_BITS-1:0] key_r;
  logic [lkc_pkg::RANK_W-1:0]   rank_r;
  logic [lkc_pkg::RANK_W-1:0]   rank_nxt;

  always_comb begin
    rank_nxt = rank_r;
    if (upd.en) begin
      if (target) begin
        rank_nxt = '0;
      end else if (lane_valid && (rank_r < upd.limit)) begin
        rank_nxt = rank_r + lkc_pkg::RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= '0;
    end else begin
      rank_r <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.en && upd.write_key && target) begin
      key_r <= key_in;
    end
  end

  assign match  = lane_valid && (key_r == key_in);
  assign oldest = lane_valid && (rank_r == last_rank);
  assign key_o  = key_r;
  assign rank_o = rank_r;

endmodule

### hdl/lkc_datapath.sv
// Datapath of the LRU key cache: entry lanes, hit and victim selection,
// capacity register and result register. Depends on lkc_pkg and lkc_lane.
module lkc_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lkc_pkg::cmd_t                  cmd,
  input  logic [lkc_pkg::IN_KEY_W-1:0]   in_key,
  input  logic                           cfg_we,
  input  logic [lkc_pkg::CAP_W-1:0]      cfg_data,
  output logic                           out_hit,
  output logic                           out_evicted,
  output logic [lkc_pkg::OUT_KEY_W-1:0]  out_evicted_key
);

  localparam int N   = lkc_pkg::MAX_ENTRIES;
  localparam int KW  = lkc_pkg::KEY_BITS;
  localparam int RW  = lkc_pkg::RANK_W;
  localparam int CW  = lkc_pkg::CNT_W;
  localparam int MW  = lkc_pkg::CMP_W;

  logic [KW-1:0]                 key_r;
  logic [lkc_pkg::CAP_W-1:0]     cap_r;
  logic [CW-1:0]                 count_r;
  logic [CW-1:0]                 count_nxt;
  logic [N-1:0]                  hit_vec_r;
  logic [N-1:0]                  old_vec_r;
  logic                          res_hit_r;
  logic                          res_evicted_r;
  logic [lkc_pkg::OUT_KEY_W-1:0] res_key_r;

  logic [N-1:0]  lane_valid;
  logic [N-1:0]  lane_match;
  logic [N-1:0]  lane_oldest;
  logic [N-1:0]  ins_vec;
  logic [N-1:0]  target_vec;
  logic [KW-1:0] lane_key [N];
  logic [RW-1:0] lane_rank [N];

  logic [CW-1:0] count_m1;
  logic [RW-1:0] last_rank;
  logic [RW-1:0] hit_rank;
  logic [KW-1:0] old_key;
  logic [MW-1:0] cap_ext;
  logic [MW-1:0] cap_eff;
  logic          enabled;
  logic          hit;
  logic          full;
  logic          evict;
  lkc_pkg::lane_upd_t upd;

  assign count_m1  = count_r - CW'(1);
  assign last_rank = count_m1[RW-1:0];

  for (genvar i = 0; i < N; i++) begin : g_lane
    assign lane_valid[i] = count_r > CW'(i);
    assign ins_vec[i]    = count_r == CW'(i);

    lkc_lane u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .lane_valid (lane_valid[i]),
      .target     (target_vec[i]),
      .key_in     (key_r),
      .last_rank  (last_rank),
      .upd        (upd),
      .match      (lane_match[i]),
      .oldest     (lane_oldest[i]),
      .key_o      (lane_key[i]),
      .rank_o     (lane_rank[i])
    );
  end

  always_comb begin
    hit_rank = '0;
    old_key  = '0;
    for (int i = 0; i < N; i++) begin
      hit_rank = hit_rank | (lane_rank[i] & {RW{hit_vec_r[i]}});
      old_key  = old_key | (lane_key[i] & {KW{old_vec_r[i]}});
    end
  end

  assign cap_ext = MW'(cap_r);
  assign cap_eff = (cap_ext > MW'(N)) ? MW'(N) : cap_ext;
  assign enabled = cap_r != '0;
  assign hit     = |hit_vec_r;
  assign full    = MW'(count_r) >= cap_eff;
  assign evict   = enabled && !hit && full;

  always_comb begin
    upd.en        = cmd.commit && enabled;
    upd.write_key = !hit;
    if (hit) begin
      upd.limit  = hit_rank;
      target_vec = hit_vec_r;
    end else if (full) begin
      upd.limit  = last_rank;
      target_vec = old_vec_r;
    end else begin
      upd.limit  = count_r[RW-1:0];
      target_vec = ins_vec;
    end
    count_nxt = count_r;
    if (cmd.commit && enabled && !hit && !full) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= '0;
      count_r   <= '0;
      hit_vec_r <= '0;
      old_vec_r <= '0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
      count_r <= count_nxt;
      if (cmd.compare) begin
        hit_vec_r <= lane_match;
        old_vec_r <= lane_oldest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= KW'(in_key);
    end
    if (cmd.commit) begin
      res_hit_r     <= enabled && hit;
      res_evicted_r <= evict;
      res_key_r     <= evict ? lkc_pkg::OUT_KEY_W'(old_key) : '0;
    end
  end

  assign out_hit         = res_hit_r;
  assign out_evicted     = res_evicted_r;
  assign out_evicted_key = res_key_r;

  a_hit_unique : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec_r))
    else $error("more than one entry matched the key");

  a_oldest_unique : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(old_vec_r))
    else $error("more than one entry holds the least recent rank");

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(N))
    else $error("entry count exceeds the store size");

endmodule

### hdl/lkc_ctrl.sv
// Controller of the LRU key cache: lookup sequencing and result handshake.
// Depends on lkc_pkg.
module lkc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output lkc_pkg::cmd_t cmd
);

  lkc_pkg::state_t state_r;
  lkc_pkg::state_t state_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic            out_free;
  logic            accept;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == lkc_pkg::S_IDLE) ||
                    ((state_r == lkc_pkg::S_UPDATE) && out_free);
  assign accept   = in_valid && in_ready;

  assign cmd.load    = accept;
  assign cmd.compare = state_r == lkc_pkg::S_LOOKUP;
  assign cmd.commit  = (state_r == lkc_pkg::S_UPDATE) && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lkc_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = lkc_pkg::S_LOOKUP;
        end
      end
      lkc_pkg::S_LOOKUP: begin
        state_nxt = lkc_pkg::S_UPDATE;
      end
      lkc_pkg::S_UPDATE: begin
        if (out_free) begin
          state_nxt = accept ? lkc_pkg::S_LOOKUP : lkc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = lkc_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lkc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_to_lookup : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == lkc_pkg::S_LOOKUP)
    else $error("accepted item did not start a lookup");

  a_lookup_to_update : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lkc_pkg::S_LOOKUP |=> state_r == lkc_pkg::S_UPDATE)
    else $error("lookup was not followed by an update");

  a_result_from_update : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == lkc_pkg::S_UPDATE)
    else $error("result appeared without an update");

endmodule

### hdl/lru_key_cache_unit.sv
// Top level of the fully associative LRU key cache.
// Depends on lkc_pkg, lkc_ctrl and lkc_datapath.
//
//   Channel  Signals                                   Direction
//   in       in_valid, in_ready, in_key                in: one key per item
//   out      out_valid, out_ready, out_hit,            out: one result per item
//            out_evicted, out_evicted_key
//   cfg      cfg_valid, cfg_ready, cfg_data            in: capacity register
//
// An item from an idle block passes accept, parallel key and rank compare over all
// entries, then the rank update with result capture.
// The next item is accepted in the update cycle, while the result of the last one is
// captured. The synchronous reset empties the store.
// A result not yet taken holds the update cycle until the output frees up.
module lru_key_cache_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [lkc_pkg::IN_KEY_W-1:0]   in_key,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_hit,
  output logic                           out_evicted,
  output logic [lkc_pkg::OUT_KEY_W-1:0]  out_evicted_key,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lkc_pkg::CAP_W-1:0]      cfg_data
);

  lkc_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  lkc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lkc_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_key          (in_key),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .out_hit         (out_hit),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key)
  );

endmodule

### bench/tb_lru_key_cache_unit.sv
// Self-checking bench for lru_key_cache_unit: a queued key driver, a result monitor and
// an LRU store model that predicts hit, eviction and evicted key for every item.
// Depends on lkc_pkg and the lru_key_cache_unit RTL only.
module tb_lru_key_cache_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                          hit;
    logic                          evicted;
    logic [lkc_pkg::OUT_KEY_W-1:0] evicted_key;
  } lookup_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [lkc_pkg::IN_KEY_W-1:0]  in_key = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          out_hit;
  logic                          out_evicted;
  logic [lkc_pkg::OUT_KEY_W-1:0] out_evicted_key;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [lkc_pkg::CAP_W-1:0]     cfg_data = '0;

  logic [lkc_pkg::KEY_BITS-1:0]  store_key [lkc_pkg::MAX_ENTRIES];
  int unsigned                   store_age [lkc_pkg::MAX_ENTRIES];
  int unsigned                   store_fill = 0;
  logic [lkc_pkg::CAP_W-1:0]     capacity_q = '0;

  logic [lkc_pkg::IN_KEY_W-1:0]  key_q [$];
  logic [lkc_pkg::IN_KEY_W-1:0]  key_pool [$];
  lookup_t                       lookup_q [$];
  lookup_t                       want;
  lookup_t                       got;

  int unsigned          idle_pct = 0;
  int unsigned          tx_gap = 0;
  int unsigned          rx_gap = 0;
  bit                   hold_go = 1'b0;
  logic                 out_hold = 1'b0;
  int unsigned          err_cnt = 0;
  int unsigned          n_keys = 0;
  int unsigned          n_results = 0;
  int unsigned          n_hits = 0;
  int unsigned          n_evicts = 0;
  int unsigned          n_cfg = 0;

  lru_key_cache_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit         (out_hit),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void age_entries(input int unsigned limit);
    for (int unsigned i = 0; i < store_fill; i++) begin
      if (store_age[i] < limit) begin
        store_age[i]++;
      end
    end
  endfunction

  function automatic lookup_t lru_lookup(input logic [lkc_pkg::IN_KEY_W-1:0] key);
    lookup_t                      r;
    int unsigned                  lim;
    int unsigned                  slot;
    int unsigned                  oldest;
    bit                           found;
    logic [lkc_pkg::KEY_BITS-1:0] k;
    r = '0;
    found = 1'b0;
    slot = 0;
    k = key;
    lim = capacity_q;
    if (lim == 0) begin
      return r;
    end
    if (lim > lkc_pkg::MAX_ENTRIES) begin
      lim = lkc_pkg::MAX_ENTRIES;
    end
    for (int unsigned i = 0; i < store_fill; i++) begin
      if (!found && store_key[i] == k) begin
        found = 1'b1;
        slot = i;
      end
    end
    if (found) begin
      age_entries(store_age[slot]);
      store_age[slot] = 0;
      r.hit = 1'b1;
    end else if (store_fill >= lim && store_fill > 0) begin
      oldest = 0;
      for (int unsigned i = 0; i < store_fill; i++) begin
        if (store_age[i] >= store_age[oldest]) begin
          oldest = i;
        end
      end
      r.evicted = 1'b1;
      r.evicted_key = store_key[oldest];
      age_entries(store_age[oldest]);
      store_key[oldest] = k;
      store_age[oldest] = 0;
    end else if (store_fill < lkc_pkg::MAX_ENTRIES) begin
      age_entries(store_fill);
      store_key[store_fill] = k;
      store_age[store_fill] = 0;
      store_fill++;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        lookup_q.push_back(lru_lookup(in_key));
        n_keys++;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (key_q.size() > 0) begin
          in_valid <= 1'b1;
          in_key <= key_q.pop_front();
          if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            tx_gap = $urandom_range(1, 19);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.hit = out_hit;
        got.evicted = out_evicted;
        got.evicted_key = out_evicted_key;
        n_results++;
        if (lookup_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("[%0t] unexpected result: hit=%b evicted=%b evicted_key=%h",
                     $realtime, got.hit, got.evicted, got.evicted_key);
          end
        end else begin
          want = lookup_q.pop_front();
          n_hits += want.hit;
          n_evicts += want.evicted;
          if (got.hit !== want.hit || got.evicted !== want.evicted ||
              got.evicted_key !== want.evicted_key) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("[%0t] mismatch: hit %b/%b evicted %b/%b evicted_key %h/%h (exp/act)",
                       $realtime, want.hit, got.hit, want.evicted, got.evicted,
                       want.evicted_key, got.evicted_key);
            end
          end
        end
      end
      if (out_hold) begin
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        rx_gap = $urandom_range(0, 18);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // The receiver backs off for a long stretch so the block fills and stalls its input.
  initial begin
    wait (hold_go);
    @(posedge clk);
    out_hold <= 1'b1;
    repeat (300) @(posedge clk);
    out_hold <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic settle();
    while (key_q.size() != 0 || in_valid || lookup_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [lkc_pkg::CAP_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cfg_valid <= 1'b0;
    capacity_q = value;
    n_cfg++;
  endtask

  task automatic random_phase(input logic [lkc_pkg::CAP_W-1:0] cap, input int unsigned n,
                              input int unsigned pct, input bit long_hold);
    int unsigned                  eff;
    int unsigned                  psize;
    int unsigned                  pick;
    logic [lkc_pkg::IN_KEY_W-1:0] k;
    settle();
    write_capacity(cap);
    idle_pct = pct;
    eff = (cap > lkc_pkg::MAX_ENTRIES) ? lkc_pkg::MAX_ENTRIES : cap;
    psize = eff + $urandom_range(1, eff / 2 + 2);
    key_pool.delete();
    for (int unsigned i = 0; i < psize; i++) begin
      key_pool.push_back($urandom);
    end
    if (long_hold) begin
      hold_go = 1'b1;
    end
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        k = (pick == 0) ? '0 : '1;
      end else if (pick < 13) begin
        k = $urandom;
      end else if (pick < 20) begin
        k = key_pool[$urandom_range(0, key_pool.size() - 1)] ^
            (32'h1 << $urandom_range(0, 31));
      end else begin
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      end
      key_q.push_back(k);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The cache is disabled out of reset.
    key_q.push_back(32'h0000_0000);
    key_q.push_back(32'hFFFF_FFFF);

    settle();
    write_capacity(7'd3);
    key_q.push_back(32'h1111_1111);
    key_q.push_back(32'h2222_2222);
    key_q.push_back(32'h3333_3333);
    key_q.push_back(32'h1111_1111);
    key_q.push_back(32'h4444_4444);
    key_q.push_back(32'h0000_0000);
    key_q.push_back(32'hFFFF_FFFF);
    key_q.push_back(32'hFFFF_FFFF);
    key_q.push_back(32'h4444_4444);

    // Disabling keeps the stored keys; they must hit again once re-enabled.
    settle();
    write_capacity(7'd0);
    key_q.push_back(32'h4444_4444);
    key_q.push_back(32'h5555_5555);

    // A capacity below the stored count evicts one key per miss.
    settle();
    write_capacity(7'd1);
    key_q.push_back(32'h0000_0000);
    key_q.push_back(32'h6666_6666);
    key_q.push_back(32'h4444_4444);
    key_q.push_back(32'h7777_7777);

    settle();
    write_capacity(7'd127);
    key_q.push_back(32'hAAAA_AAAA);
    key_q.push_back(32'h5555_5555);
    key_q.push_back(32'h4444_4444);

    random_phase(7'd64, 150, 10, 1'b0);
    random_phase(7'd127, 150, 25, 1'b0);
    random_phase(7'd1, 120, 10, 1'b0);
    random_phase(7'd2, 120, 40, 1'b0);
    random_phase(7'd16, 160, 15, 1'b1);
    random_phase(7'd8, 150, 0, 1'b0);
    random_phase(7'd0, 60, 20, 1'b0);
    random_phase(7'd65, 150, 10, 1'b0);
    random_phase(7'd5, 140, 30, 1'b0);
    random_phase(7'd33, 150, 10, 1'b0);
    random_phase(7'd64, 200, 0, 1'b0);

    settle();
    repeat (6) @(posedge clk);
    $display("Looked up %0d keys over %0d capacity settings, from disabled to above store size.",
             n_keys, n_cfg);
    $display("Checked %0d results: %0d hits, %0d evictions, %0d mismatches.",
             n_results, n_hits, n_evicts, err_cnt);
    if (err_cnt == 0 && lookup_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
